// File: rtl/swrc_pkg.sv
package swrc_pkg;

	// Field widths
	localparam int TIME_BITS_DEF = 48;
	localparam int FUNC_W        = 2;
	localparam int LEN_W         = 31;
	localparam int COUNT_W       = 32;
	localparam int PROD_W        = COUNT_W + LEN_W;

	// Window length after reset
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

	// Saturation value of the counters
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Operation codes on the input channel
	localparam logic [FUNC_W-1:0] FUNC_RECORD = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RESET  = 2'd2;

	// Queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	// Divider iteration counter
	localparam int DIV_CNT_W = 6;

	// Classified operation handed to the back end
	typedef enum logic [1:0] {
		KIND_RECORD,
		KIND_QUERY,
		KIND_RESET
	} kind_t;

	// Map an operation code onto its kind; unused codes act as queries
	function automatic kind_t classify(input logic [FUNC_W-1:0] func);
		kind_t k;
		unique case (func)
			FUNC_RECORD: k = KIND_RECORD;
			FUNC_RESET:  k = KIND_RESET;
			default:     k = KIND_QUERY;
		endcase
		return k;
	endfunction

endpackage

// File: rtl/swrc_front.sv
module swrc_front #(
	parameter int TIME_BITS = swrc_pkg::TIME_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [swrc_pkg::FUNC_W-1:0] s_func,
	input  logic [TIME_BITS-1:0]        s_time,
	output logic                        q_valid,
	input  logic                        q_ready,
	output swrc_pkg::kind_t             q_kind,
	output logic [TIME_BITS-1:0]        q_time
);

	swrc_pkg::kind_t                    kind_q [swrc_pkg::Q_DEPTH];
	logic [TIME_BITS-1:0]               time_q [swrc_pkg::Q_DEPTH];
	logic [swrc_pkg::Q_PTR_W-1:0]       wr_ptr_q;
	logic [swrc_pkg::Q_PTR_W-1:0]       rd_ptr_q;
	logic [swrc_pkg::Q_CNT_W-1:0]       count_q;
	logic                               push;
	logic                               pop;

	// Accept while the queue has room
	assign s_tready = (count_q != swrc_pkg::Q_CNT_W'(swrc_pkg::Q_DEPTH));
	assign q_valid  = (count_q != '0);
	assign q_kind   = kind_q[rd_ptr_q];
	assign q_time   = time_q[rd_ptr_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_valid && q_ready;

	// Store classified items
	always_ff @(posedge clk) begin
		if (push) begin
			kind_q[wr_ptr_q] <= swrc_pkg::classify(s_func);
			time_q[wr_ptr_q] <= s_time;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/swrc_div.sv
module swrc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [swrc_pkg::PROD_W-1:0]   dividend,
	input  logic [swrc_pkg::LEN_W-1:0]    divisor,
	output logic                          done,
	output logic [swrc_pkg::COUNT_W-1:0]  quotient
);

	// Quotient is known to fit COUNT_W bits, so the upper dividend part
	// starts below the divisor and only COUNT_W steps are needed.
	logic [swrc_pkg::LEN_W-1:0]     rem_q;
	logic [swrc_pkg::COUNT_W-1:0]   dvd_q;
	logic [swrc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic [swrc_pkg::LEN_W:0]       trial;
	logic                           fits;

	assign trial    = {rem_q, dvd_q[swrc_pkg::COUNT_W-1]};
	assign fits     = (trial >= {1'b0, divisor});
	assign done     = busy_q && (cnt_q == '0);
	assign quotient = dvd_q;

	// Shift in one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[swrc_pkg::PROD_W-1:swrc_pkg::COUNT_W];
			dvd_q <= dividend[swrc_pkg::COUNT_W-1:0];
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= fits ? swrc_pkg::LEN_W'(trial - {1'b0, divisor})
			              : trial[swrc_pkg::LEN_W-1:0];
			dvd_q <= {dvd_q[swrc_pkg::COUNT_W-2:0], fits};
		end
	end

	// Count steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= swrc_pkg::DIV_CNT_W'(swrc_pkg::COUNT_W);
		end else if (busy_q) begin
			if (cnt_q == '0)
				busy_q <= 1'b0;
			else
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: rtl/swrc_back.sv
module swrc_back #(
	parameter int TIME_BITS = swrc_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [swrc_pkg::LEN_W-1:0]    len,
	input  logic                          q_valid,
	output logic                          q_ready,
	input  swrc_pkg::kind_t               q_kind,
	input  logic [TIME_BITS-1:0]          q_time,
	output logic                          m_valid,
	input  logic                          m_ready,
	output logic [swrc_pkg::COUNT_W-1:0]  m_count,
	output logic                          m_rotated
);

	localparam int CMP_W = (TIME_BITS > swrc_pkg::LEN_W) ? TIME_BITS : swrc_pkg::LEN_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPLY,
		ST_WEIGHT,
		ST_MUL,
		ST_START,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                          state_q;
	swrc_pkg::kind_t                 kind_q;
	logic [TIME_BITS-1:0]            now_q;
	logic [TIME_BITS-1:0]            start_q;
	logic [swrc_pkg::COUNT_W-1:0]    cur_q;
	logic [swrc_pkg::COUNT_W-1:0]    prev_q;
	logic                            roll_q;
	logic [swrc_pkg::LEN_W-1:0]      weight_q;
	logic [swrc_pkg::PROD_W-1:0]     prod_q;
	logic [swrc_pkg::COUNT_W-1:0]    quot_q;
	logic [swrc_pkg::COUNT_W-1:0]    count_q;
	logic                            rot_out_q;
	logic                            out_valid_q;

	logic                            later;
	logic [TIME_BITS-1:0]            diff;
	logic [CMP_W-1:0]                diff_x;
	logic [CMP_W-1:0]                len_x;
	logic                            roll;
	logic [swrc_pkg::LEN_W-1:0]      elapsed;
	logic [swrc_pkg::COUNT_W:0]      sum;
	logic                            div_start;
	logic                            div_done;
	logic [swrc_pkg::COUNT_W-1:0]    div_quot;

	// Elapsed time against the current window start
	assign later   = (now_q >= start_q);
	assign diff    = now_q - start_q;
	assign diff_x  = CMP_W'(diff);
	assign len_x   = CMP_W'(len);
	assign roll    = (kind_q == swrc_pkg::KIND_RECORD) && later && (diff_x >= len_x);
	assign elapsed = !later          ? '0 :
	                 (diff_x > len_x) ? len : diff_x[swrc_pkg::LEN_W-1:0];

	// Final sum with saturation
	assign sum = {1'b0, cur_q} + {1'b0, quot_q};

	assign q_ready   = (state_q == ST_IDLE);
	assign div_start = (state_q == ST_START);
	assign m_valid   = out_valid_q;
	assign m_count   = count_q;
	assign m_rotated = rot_out_q;

	swrc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (len),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Sequence one item: update state, weight, multiply, divide, deliver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= '0;
			cur_q       <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Raise the result when the output register is free, drop it once taken
			if (state_q == ST_DONE && (!out_valid_q || m_ready))
				out_valid_q <= 1'b1;
			else if (out_valid_q && m_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid)
						state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					case (kind_q)
						swrc_pkg::KIND_RECORD: begin
							if (roll) begin
								prev_q  <= cur_q;
								start_q <= now_q;
								cur_q   <= swrc_pkg::COUNT_W'(1);
							end else if (cur_q != swrc_pkg::COUNT_MAX) begin
								cur_q <= cur_q + 1'b1;
							end
						end
						swrc_pkg::KIND_RESET: begin
							start_q <= now_q;
							cur_q   <= '0;
							prev_q  <= '0;
						end
						default: ;
					endcase
					state_q <= ST_WEIGHT;
				end
				ST_WEIGHT: state_q <= ST_MUL;
				ST_MUL:    state_q <= ST_START;
				ST_START:  state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || m_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			kind_q <= q_kind;
			now_q  <= q_time;
		end
		if (state_q == ST_APPLY)
			roll_q <= roll;
		if (state_q == ST_WEIGHT)
			weight_q <= len - elapsed;
		if (state_q == ST_MUL)
			prod_q <= swrc_pkg::PROD_W'(prev_q * weight_q);
		if (state_q == ST_DIV && div_done)
			quot_q <= div_quot;
		if (state_q == ST_DONE && (!out_valid_q || m_ready)) begin
			count_q   <= sum[swrc_pkg::COUNT_W] ? swrc_pkg::COUNT_MAX
			                                    : sum[swrc_pkg::COUNT_W-1:0];
			rot_out_q <= roll_q;
		end
	end

endmodule

// File: rtl/sliding_window_rate_counter_top.sv
// Sliding window rate counter.
// Input channel s_*: one item per operation. s_tuser carries the operation
// (record, query, reset; the unused code acts as a query), s_tdata the
// millisecond timestamp. Output channel m_*: exactly one item per input item,
// in order; m_tdata is the interpolated count, m_tuser the rotate flag.
// Config channel cfg_*: writes the window length; zero is taken as one.
// Write it only while no item is in flight.
// The execution side takes one item at a time and starts the next only after
// the last result has been handed to the output register. It applies the
// operation, weights the previous count, and then the 32-step shift-subtract
// divider divides the weighted previous count by the window length.
// A two-entry queue sits behind the input, so up to two items are taken
// while the execution side is busy; s_tready drops when it is full.
// When the receiver stalls, the result holds in the output register and the
// execution side waits with the next result until it is taken.
// Reset clears counts, window start and queue, and sets the length to one.
module sliding_window_rate_counter_top #(
	parameter int TIME_BITS = swrc_pkg::TIME_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// tdata: now_time
	input  logic [((TIME_BITS+7)/8)*8-1:0] s_tdata,
	// tuser: func
	input  logic [swrc_pkg::FUNC_W-1:0]  s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// tdata: effective_count
	output logic [swrc_pkg::COUNT_W-1:0] m_tdata,
	// tuser: rotated
	output logic                         m_tuser,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [swrc_pkg::LEN_W-1:0]   cfg_data
);

	logic [swrc_pkg::LEN_W-1:0] len_q;
	logic                       q_valid;
	logic                       q_ready;
	swrc_pkg::kind_t            q_kind;
	logic [TIME_BITS-1:0]       q_time;

	assign cfg_ready = 1'b1;

	// Hold the window length, zero stored as one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			len_q <= swrc_pkg::LEN_RESET;
		else if (cfg_valid && cfg_ready)
			len_q <= (cfg_data == '0) ? swrc_pkg::LEN_RESET : cfg_data;
	end

	swrc_front #(.TIME_BITS(TIME_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_func   (s_tuser),
		.s_time   (s_tdata[TIME_BITS-1:0]),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_kind   (q_kind),
		.q_time   (q_time)
	);

	swrc_back #(.TIME_BITS(TIME_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.len       (len_q),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_kind    (q_kind),
		.q_time    (q_time),
		.m_valid   (m_tvalid),
		.m_ready   (m_tready),
		.m_count   (m_tdata),
		.m_rotated (m_tuser)
	);

endmodule

// File: rtl/swrc_checker.sv
module swrc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [swrc_pkg::COUNT_W-1:0] m_tdata,
	input logic                         m_tuser
);

	logic m_hs;

	assign m_hs = m_tvalid && m_tready;

	// Stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// A rollover counts the new event, so the count is never zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata != '0)
		else $error("rotated result with zero count");

	// Only one result can wait behind the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		m_hs ##1 m_hs |=> !m_hs)
		else $error("three results delivered back to back");

endmodule

bind sliding_window_rate_counter_top swrc_checker u_swrc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
